@@ sv/mm64a_pkg.sv @@
package mm64a_pkg;

  localparam logic [63:0] MIX_M = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_R = 47;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] xor_shift(input logic [63:0] x);
    return x ^ (x >> MIX_R);
  endfunction

endpackage

@@ sv/murmur64a_hash_stream_top.sv @@
// Every multiply by M runs on the one shared 32x32 multiplier.
// An item takes n = 0..5 multiplies (length on a first word, three for a
// full word, one for a partial word, one for the finish); a last item then passes through
// S_DONE to hand its hash to the output register.
// Throughput: one item at a time; the next is taken once the current one is through.
// Reset: asynchronous, active low; clears the sequencer, the seed and the output valid.
module murmur64a_hash_stream_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hash_seed_we_i,
  input  logic [63:0] hash_seed_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic [31:0] message_length_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INIT = 8'b0000_0010,
    S_WORD = 8'b0000_0100,
    S_K1   = 8'b0000_1000,
    S_K2   = 8'b0001_0000,
    S_HM   = 8'b0010_0000,
    S_F1   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [63:0]         seed_q;
  logic [63:0]         h_q, h_d;
  logic                mid_q, mid_d;
  logic [63:0]         word_q;
  logic [3:0]          nb_q;
  logic                last_q;
  logic [63:0]         res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [63:0]         hash_q, hash_d;
  logic [63:0]         mask;
  logic [3:0]          nb_sat;
  logic                in_fire;
  mm64a_pkg::mul_req_t mul_req;
  mm64a_pkg::mul_rsp_t mul_rsp;

  mm64a_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign nb_sat     = (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i*8 +: 8] = (4'(i) < nb_q) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    mid_d       = mid_q;
    res_d       = res_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_req     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (mid_q) begin
            state_d = S_WORD;
          end else begin
            mul_req.start   = 1'b1;
            mul_req.operand = {32'd0, message_length_i};
            state_d         = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (mul_rsp.done) begin
          h_d     = seed_q ^ mul_rsp.product;
          state_d = S_WORD;
        end
      end
      S_WORD: begin
        if (nb_q == 4'd8) begin
          mul_req.start   = 1'b1;
          mul_req.operand = word_q;
          state_d         = S_K1;
        end else if (nb_q != 4'd0) begin
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ (word_q & mask);
          state_d         = S_HM;
        end else if (last_q) begin
          mul_req.start   = 1'b1;
          mul_req.operand = mm64a_pkg::xor_shift(h_q);
          state_d         = S_F1;
        end else begin
          mid_d   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_K1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = mm64a_pkg::xor_shift(mul_rsp.product);
          state_d         = S_K2;
        end
      end
      S_K2: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ mul_rsp.product;
          state_d         = S_HM;
        end
      end
      S_HM: begin
        if (mul_rsp.done) begin
          if (last_q) begin
            mul_req.start   = 1'b1;
            mul_req.operand = mm64a_pkg::xor_shift(mul_rsp.product);
            state_d         = S_F1;
          end else begin
            h_d     = mul_rsp.product;
            mid_d   = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_F1: begin
        if (mul_rsp.done) begin
          res_d   = mm64a_pkg::xor_shift(mul_rsp.product);
          h_d     = '0;
          mid_d   = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          hash_d      = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mid_q       <= 1'b0;
      h_q         <= '0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mid_q       <= mid_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
      if (hash_seed_we_i) begin
        seed_q <= hash_seed_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    hash_q <= hash_d;
    if (in_fire) begin
      word_q <= data_word_i;
      nb_q   <= nb_sat;
      last_q <= last_word_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  a_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == S_INIT || state_q == S_K1 || state_q == S_K2 ||
                      state_q == S_HM || state_q == S_F1))
    else $error("multiplier result with no consumer");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready right after an input beat");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("output beat not from finish");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> !mid_q && h_q == '0)
    else $error("accumulator not cleared at message end");

endmodule

@@ sv/mm64a_mul.sv @@
// Multiplies a 64-bit operand by MIX_M modulo 2^64 through one 32x32 multiplier.
module mm64a_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mm64a_pkg::mul_req_t req_i,
  output mm64a_pkg::mul_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    STEP_LL = 3'b001,
    STEP_LH = 3'b010,
    STEP_HL = 3'b100
  } mul_step_e;

  logic [63:0] a_q;
  logic [63:0] acc_q, acc_d;
  mul_step_e   step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] op_a, op_b;
  logic [63:0] pp;

  always_comb begin
    op_a = a_q[31:0];
    op_b = mm64a_pkg::MIX_M[31:0];
    case (step_q)
      STEP_LL: begin
        op_a = a_q[31:0];
        op_b = mm64a_pkg::MIX_M[31:0];
      end
      STEP_LH: begin
        op_a = a_q[31:0];
        op_b = mm64a_pkg::MIX_M[63:32];
      end
      STEP_HL: begin
        op_a = a_q[63:32];
        op_b = mm64a_pkg::MIX_M[31:0];
      end
      default: begin
        op_a = a_q[31:0];
        op_b = mm64a_pkg::MIX_M[31:0];
      end
    endcase
  end

  assign pp = op_a * op_b;

  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      step_d = STEP_LL;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (step_q == STEP_LL) begin
        acc_d  = pp;
        step_d = STEP_LH;
      end else begin
        acc_d = acc_q + {pp[31:0], 32'd0};
        if (step_q == STEP_LH) begin
          step_d = STEP_HL;
        end else begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LL;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (req_i.start) begin
      a_q <= req_i.operand;
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("multiplier restarted while busy");

  a_done_after_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(step_q == STEP_HL) && $past(busy_q))
    else $error("multiplier done without final step");

endmodule

@@ sim/murmur64a_hash_stream_top_test.sv @@
`timescale 1ns / 100ps

module murmur64a_hash_stream_top_test;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int IDLE_PCT      = 34;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 500;
  localparam int PHASE_ITEMS   = 175;
  localparam int NUM_PHASES    = 6;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic [31:0] len;
    logic        last;
  } word_item_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        hash_seed_we_i   = 1'b0;
  logic [63:0] hash_seed_i      = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_word_i      = '0;
  logic [3:0]  valid_bytes_i    = '0;
  logic [31:0] message_length_i = '0;
  logic        last_word_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [63:0] hash_value_o;

  word_item_t  word_q[$];
  logic [63:0] expected_hash_q[$];

  logic [63:0] seed_q   = '0;
  logic [63:0] accum_q  = '0;
  logic        mid_q    = 1'b0;

  bit  steady   = 1'b0;
  bit  hold_out = 1'b0;
  int  err_cnt  = 0;
  int  pushed_cnt = 0;
  int  cycle_cnt  = 0;

  murmur64a_hash_stream_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .hash_seed_we_i   (hash_seed_we_i),
    .hash_seed_i      (hash_seed_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_word_i      (data_word_i),
    .valid_bytes_i    (valid_bytes_i),
    .message_length_i (message_length_i),
    .last_word_i      (last_word_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hash_value_o     (hash_value_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_error(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    err_cnt = err_cnt + 1;
  endtask

  // Fold one accepted beat into the running hash; a last beat yields the hash.
  task automatic fold_word(input word_item_t it);
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] mask;
    int          nb;
    nb = (it.nbytes > 4'd8) ? 8 : int'(it.nbytes);
    h  = mid_q ? accum_q : (seed_q ^ ({32'h0, it.len} * mm64a_pkg::MIX_M));
    if (nb == 8) begin
      k = it.word * mm64a_pkg::MIX_M;
      k = k ^ (k >> mm64a_pkg::MIX_R);
      k = k * mm64a_pkg::MIX_M;
      h = (h ^ k) * mm64a_pkg::MIX_M;
    end else if (nb != 0) begin
      mask = (64'h1 << (nb * 8)) - 64'h1;
      h    = (h ^ (it.word & mask)) * mm64a_pkg::MIX_M;
    end
    if (!it.last) begin
      accum_q = h;
      mid_q   = 1'b1;
    end else begin
      h = h ^ (h >> mm64a_pkg::MIX_R);
      h = h * mm64a_pkg::MIX_M;
      h = h ^ (h >> mm64a_pkg::MIX_R);
      expected_hash_q.push_back(h);
      accum_q = '0;
      mid_q   = 1'b0;
    end
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      data_word_i      <= '0;
      valid_bytes_i    <= '0;
      message_length_i <= '0;
      last_word_i      <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        fold_word(word_q.pop_front());
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (word_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i       <= 1'b1;
          data_word_i      <= word_q[0].word;
          valid_bytes_i    <= word_q[0].nbytes;
          message_length_i <= word_q[0].len;
          last_word_i      <= word_q[0].last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_hash_q.size() == 0) begin
          report_error($sformatf("unexpected hash %h", hash_value_o));
        end else begin
          logic [63:0] exp_hash;
          exp_hash = expected_hash_q.pop_front();
          if (hash_value_o !== exp_hash)
            report_error($sformatf("hash_value got %h exp %h", hash_value_o, exp_hash));
        end
      end
      out_ready_i <= !hold_out && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(input logic [63:0] word, input logic [3:0] nbytes,
                           input logic [31:0] len, input logic last);
    word_item_t it;
    it.word   = word;
    it.nbytes = nbytes;
    it.len    = len;
    it.last   = last;
    word_q.push_back(it);
    pushed_cnt = pushed_cnt + 1;
  endtask

  // Well-formed message of nbytes bytes; the length field may lie.
  task automatic add_message(input int nbytes, input logic [31:0] claimed);
    int          left;
    int          take;
    bit          first;
    logic [3:0]  vb;
    left  = nbytes;
    first = 1'b1;
    if (nbytes == 0)
      push_item(rand64(), 4'd0, claimed, 1'b1);
    while (left > 0) begin
      take = (left >= 8) ? 8 : left;
      left = left - take;
      if (take == 8)
        vb = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 9)) : 4'd8;
      else
        vb = 4'(take);
      push_item(rand64(), vb, first ? claimed : 32'($urandom), left == 0);
      first = 1'b0;
    end
  endtask

  task automatic settle();
    while (word_q.size() != 0 || expected_hash_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_seed(input logic [63:0] value);
    @(posedge clk_i);
    hash_seed_we_i <= 1'b1;
    hash_seed_i    <= value;
    @(posedge clk_i);
    hash_seed_we_i <= 1'b0;
    seed_q = value;
    @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] seed;
    int          start_cnt;
    int          nbytes;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset seed of zero
    push_item(rand64(), 4'd0, 32'd0, 1'b1);
    push_item(64'h0, 4'd0, 32'hFFFF_FFFF, 1'b1);
    push_item('1, 4'd8, 32'd8, 1'b1);
    push_item('0, 4'd8, 32'd8, 1'b1);
    push_item('1, 4'd1, 32'd1, 1'b1);
    push_item('1, 4'd7, 32'd7, 1'b1);
    push_item(rand64(), 4'd9, 32'd8, 1'b1);
    push_item('1, 4'd15, 32'hFFFF_FFFF, 1'b1);
    push_item(rand64(), 4'd8, 32'd13, 1'b0);
    push_item('1, 4'd5, '1, 1'b1);
    push_item(rand64(), 4'd0, 32'd16, 1'b0);
    push_item(rand64(), 4'd8, '0, 1'b1);
    push_item('1, 4'd3, 32'd24, 1'b0);
    push_item(rand64(), 4'd8, '0, 1'b1);
    push_item(rand64(), 4'd8, 32'd24, 1'b0);
    push_item(rand64(), 4'd8, '1, 1'b0);
    push_item(rand64(), 4'd8, '0, 1'b1);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       seed = '1;
        1:       seed = 64'h1;
        3:       seed = 64'h8000_0000_0000_0000;
        5:       seed = '0;
        default: seed = rand64();
      endcase
      write_seed(seed);
      steady = (p == 1);
      start_cnt = pushed_cnt;
      while (pushed_cnt - start_cnt < PHASE_ITEMS) begin
        if ($urandom_range(99) < 85) begin
          nbytes = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(40);
          add_message(nbytes, ($urandom_range(7) == 0) ? 32'($urandom) : 32'(nbytes));
        end else begin
          push_item(rand64(), 4'($urandom_range(15)), 32'($urandom), 1'($urandom));
        end
      end
      // leave a message open across the next seed write
      if (p == 3)
        push_item(rand64(), 4'd8, 32'($urandom), 1'b0);
      if (p == 2) begin
        hold_out = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_out = 1'b0;
      end
      settle();
    end
    steady = 1'b0;

    if (expected_hash_q.size() != 0)
      report_error($sformatf("%0d hashes never arrived", expected_hash_q.size()));
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
